// ===== rtl/core/skv_pkg.sv =====
// Shared types and codes for the sorted key/value table.
package skv_pkg;

   localparam int KEY_PORT_BITS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int STATUS_BITS   = 3;
   localparam int OP_BITS       = 2;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_DUMP   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_ENTRY    = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_UPDATED  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_DELETED  = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd7;

   typedef struct packed {
      logic [OP_BITS-1:0]       op;
      logic [KEY_PORT_BITS-1:0] key;
      logic [VALUE_BITS-1:0]    low;
      logic [VALUE_BITS-1:0]    high;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [KEY_PORT_BITS-1:0] key;
      logic [VALUE_BITS-1:0]    low;
      logic [VALUE_BITS-1:0]    high;
      logic                     last;
   } rsp_type;

endpackage

// ===== rtl/core/skv_front.sv =====
// Request front end: accepts transactions, masks the key and queues commands.
module skv_front #(
   parameter int KEY_W = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [skv_pkg::OP_BITS-1:0]           req_operation,
   input  logic [skv_pkg::KEY_PORT_BITS-1:0]     req_entry_key,
   input  logic [skv_pkg::VALUE_BITS-1:0]        req_low_value,
   input  logic [skv_pkg::VALUE_BITS-1:0]        req_high_value,
   output logic                                  head_valid,
   output skv_pkg::cmd_type                      head_cmd,
   input  logic                                  head_pop
);

   localparam int DEPTH = skv_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KPW   = skv_pkg::KEY_PORT_BITS;

   skv_pkg::cmd_type   slot_ff [DEPTH];
   skv_pkg::cmd_type   new_cmd;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               accept;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign accept     = push && !full;

   always_comb begin
      new_cmd.op   = req_operation;
      new_cmd.key  = KPW'(req_entry_key[KEY_W-1:0]);
      new_cmd.low  = req_low_value;
      new_cmd.high = req_high_value;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !head_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!accept && head_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/core/skv_table.sv =====
// Back end: a row of sorted cells with parallel compare, shift and rotate, plus the result register.
module skv_table #(
   parameter int CAPACITY = 32,
   parameter int KEY_W    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  skv_pkg::cmd_type    head_cmd,
   output logic                head_pop,
   output logic                empty,
   input  logic                pop,
   output skv_pkg::rsp_type    rsp
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int KPW = skv_pkg::KEY_PORT_BITS;
   localparam int VW  = skv_pkg::VALUE_BITS;

   localparam logic MODE_CMD  = 1'b0;
   localparam logic MODE_DUMP = 1'b1;

   logic [KEY_W-1:0]  key_ff  [CAPACITY];
   logic [KEY_W-1:0]  key_in  [CAPACITY];
   logic [VW-1:0]     low_ff  [CAPACITY];
   logic [VW-1:0]     low_in  [CAPACITY];
   logic [VW-1:0]     high_ff [CAPACITY];
   logic [VW-1:0]     high_in [CAPACITY];

   logic [CAPACITY-1:0] cell_valid;
   logic [CAPACITY-1:0] cell_lt;
   logic [CAPACITY-1:0] cell_eq;

   logic              mode_ff, mode_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     remain_ff, remain_in;
   logic [CW-1:0]     last_idx;
   logic              rsp_valid_ff, rsp_valid_in;
   skv_pkg::rsp_type  rsp_ff, rsp_in;

   logic [KEY_W-1:0]  cmd_key;
   logic              load;
   logic              cmd_go;
   logic              found;
   logic              table_full;
   logic              do_insert;
   logic              do_update;
   logic              do_delete;
   logic              dump_emit;

   assign cmd_key    = head_cmd.key[KEY_W-1:0];
   assign load       = !rsp_valid_ff || pop;
   assign cmd_go     = (mode_ff == MODE_CMD) && head_valid && load;
   assign head_pop   = cmd_go;
   assign found      = |cell_eq;
   assign table_full = (count_ff == CW'(CAPACITY));
   assign last_idx   = count_ff - 1'b1;
   assign do_insert  = cmd_go && (head_cmd.op == skv_pkg::OP_INSERT) && !found && !table_full;
   assign do_update  = cmd_go && (head_cmd.op == skv_pkg::OP_INSERT) && found;
   assign do_delete  = cmd_go && (head_cmd.op == skv_pkg::OP_DELETE) && found;
   assign dump_emit  = load && (((mode_ff == MODE_CMD) && head_valid &&
                                 (head_cmd.op == skv_pkg::OP_DUMP) && (count_ff != '0)) ||
                                (mode_ff == MODE_DUMP));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [KEY_W-1:0] next_key;
      logic [VW-1:0]    prev_low;
      logic [VW-1:0]    next_low;
      logic [VW-1:0]    prev_high;
      logic [VW-1:0]    next_high;
      logic             prev_lt;
      logic             prev_ge;

      assign cell_valid[i] = (CW'(i) < count_ff);
      assign cell_lt[i]    = cell_valid[i] && (key_ff[i] < cmd_key);
      assign cell_eq[i]    = cell_valid[i] && (key_ff[i] == cmd_key);

      if (i == 0) begin : g_first
         assign prev_key  = cmd_key;
         assign prev_low  = head_cmd.low;
         assign prev_high = head_cmd.high;
         assign prev_lt   = 1'b1;
         assign prev_ge   = 1'b0;
      end else begin : g_inner
         assign prev_key  = key_ff[i-1];
         assign prev_low  = low_ff[i-1];
         assign prev_high = high_ff[i-1];
         assign prev_lt   = cell_lt[i-1];
         assign prev_ge   = cell_valid[i-1] && !cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_key  = key_ff[i];
         assign next_low  = low_ff[i];
         assign next_high = high_ff[i];
      end else begin : g_body
         assign next_key  = key_ff[i+1];
         assign next_low  = low_ff[i+1];
         assign next_high = high_ff[i+1];
      end

      always_comb begin
         key_in[i]  = key_ff[i];
         low_in[i]  = low_ff[i];
         high_in[i] = high_ff[i];
         if (do_insert) begin
            if (prev_ge) begin
               key_in[i]  = prev_key;
               low_in[i]  = prev_low;
               high_in[i] = prev_high;
            end else if (prev_lt && !cell_lt[i]) begin
               key_in[i]  = cmd_key;
               low_in[i]  = head_cmd.low;
               high_in[i] = head_cmd.high;
            end
         end
         if (do_update && cell_eq[i]) begin
            low_in[i]  = head_cmd.low;
            high_in[i] = head_cmd.high;
         end
         if (do_delete && !cell_lt[i]) begin
            key_in[i]  = next_key;
            low_in[i]  = next_low;
            high_in[i] = next_high;
         end
         if (dump_emit) begin
            if (last_idx == CW'(i)) begin
               key_in[i]  = key_ff[0];
               low_in[i]  = low_ff[0];
               high_in[i] = high_ff[0];
            end else begin
               key_in[i]  = next_key;
               low_in[i]  = next_low;
               high_in[i] = next_high;
            end
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i]  <= key_in[i];
         low_ff[i]  <= low_in[i];
         high_ff[i] <= high_in[i];
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in       = rsp_ff;
      unique case (mode_ff)
         MODE_CMD: begin
            if (cmd_go) begin
               rsp_valid_in = 1'b1;
               rsp_in.key   = head_cmd.key;
               rsp_in.low   = '0;
               rsp_in.high  = '0;
               rsp_in.last  = 1'b1;
               unique case (head_cmd.op)
                  skv_pkg::OP_INSERT: begin
                     if (found) begin
                        rsp_in.status = skv_pkg::ST_UPDATED;
                     end else if (table_full) begin
                        rsp_in.status = skv_pkg::ST_FULL;
                     end else begin
                        rsp_in.status = skv_pkg::ST_INSERTED;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  skv_pkg::OP_DELETE: begin
                     if (found) begin
                        rsp_in.status = skv_pkg::ST_DELETED;
                        count_in      = count_ff - 1'b1;
                     end else begin
                        rsp_in.status = skv_pkg::ST_NOTFOUND;
                     end
                  end
                  skv_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = skv_pkg::ST_EMPTY;
                        rsp_in.key    = '0;
                     end else begin
                        rsp_in.status = skv_pkg::ST_ENTRY;
                        rsp_in.key    = KPW'(key_ff[0]);
                        rsp_in.low    = low_ff[0];
                        rsp_in.high   = high_ff[0];
                        rsp_in.last   = (count_ff == CW'(1));
                        remain_in     = count_ff - 1'b1;
                        if (count_ff != CW'(1)) begin
                           mode_in = MODE_DUMP;
                        end
                     end
                  end
                  skv_pkg::OP_CLEAR: begin
                     rsp_in.status = skv_pkg::ST_CLEARED;
                     rsp_in.key    = '0;
                     count_in      = '0;
                  end
                  default: begin
                     rsp_in.status = skv_pkg::ST_NOTFOUND;
                  end
               endcase
            end
         end
         MODE_DUMP: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = skv_pkg::ST_ENTRY;
               rsp_in.key    = KPW'(key_ff[0]);
               rsp_in.low    = low_ff[0];
               rsp_in.high   = high_ff[0];
               rsp_in.last   = (remain_ff == CW'(1));
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == CW'(1)) begin
                  mode_in = MODE_CMD;
               end
            end
         end
         default: begin
            mode_in = MODE_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CMD;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign empty = !rsp_valid_ff;
   assign rsp   = rsp_ff;

endmodule

// ===== rtl/core/sorted_key_value_table.sv =====
// Top level of the sorted key/value table.
// This table keeps up to CAPACITY entries in ascending key order, each a key and two stored
// 32-bit values. Requests enter a two-deep command queue and are carried out by a row of cells
// that compares every stored key against the request key at once and shifts in the same
// cycle. A steady stream of inserts, deletes and clears runs at one transaction per clock
// as long as each result is popped, since an unpopped result stalls the row; a result
// appears in the cycle after its request is taken. A dump rotates the row one place per
// clock and returns one entry per clock while results are popped, holding the row until
// every entry is returned (an empty table gives one ST_EMPTY result). Results wait in one
// output register; the queue keeps taking requests while a result is not yet popped.
module sorted_key_value_table #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [skv_pkg::OP_BITS-1:0]       req_operation,
   input  logic [skv_pkg::KEY_PORT_BITS-1:0] req_entry_key,
   input  logic [skv_pkg::VALUE_BITS-1:0]    req_low_value,
   input  logic [skv_pkg::VALUE_BITS-1:0]    req_high_value,
   output logic                              empty,
   input  logic                              pop,
   output logic [skv_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [skv_pkg::KEY_PORT_BITS-1:0] rsp_out_key,
   output logic [skv_pkg::VALUE_BITS-1:0]    rsp_out_low,
   output logic [skv_pkg::VALUE_BITS-1:0]    rsp_out_high,
   output logic                              rsp_last
);

   localparam int KW = (KEY_BITS < skv_pkg::KEY_PORT_BITS) ? KEY_BITS : skv_pkg::KEY_PORT_BITS;

   logic              head_valid;
   logic              head_pop;
   skv_pkg::cmd_type  head_cmd;
   skv_pkg::rsp_type  rsp;

   skv_front #(
      .KEY_W (KW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_operation  (req_operation),
      .req_entry_key  (req_entry_key),
      .req_low_value  (req_low_value),
      .req_high_value (req_high_value),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .head_pop       (head_pop)
   );

   skv_table #(
      .CAPACITY (CAPACITY),
      .KEY_W    (KW)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp        (rsp)
   );

   assign rsp_status   = rsp.status;
   assign rsp_out_key  = rsp.key;
   assign rsp_out_low  = rsp.low;
   assign rsp_out_high = rsp.high;
   assign rsp_last     = rsp.last;

endmodule
